// ===== hw/rtl/tvsu_pkg.sv =====
// tvsu_pkg: shared types and constants of the timer and video sync unit
// item and result layouts, command and register codes, fixed counts
// no dependencies
`default_nettype none

package tvsu_pkg;

	// command codes on the input tuser
	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_WRITE   = 3'd1;
	localparam logic [2:0] CMD_READ    = 3'd2;
	localparam logic [2:0] CMD_KEY     = 3'd3;
	localparam logic [2:0] CMD_RELEASE = 3'd4;

	// register offsets from the unit base
	localparam logic [5:0] ADDR_STATUS  = 6'h00;
	localparam logic [5:0] ADDR_PORTC   = 6'h01;
	localparam logic [5:0] ADDR_KEYCTL  = 6'h03;
	localparam logic [5:0] ADDR_TCTRL   = 6'h05;
	localparam logic [5:0] ADDR_TMSB    = 6'h06;
	localparam logic [5:0] ADDR_TLSB    = 6'h07;
	localparam logic [5:0] ADDR_LINE    = 6'h0a;
	localparam logic [5:0] ADDR_AUX     = 6'h24;
	localparam logic [5:0] ADDR_WINDOW  = 6'h27;

	// interrupt status bits
	localparam logic [7:0] STATUS_ANY       = 8'h80;
	localparam logic [7:0] STATUS_TIMER_SET = 8'h81;
	localparam logic [7:0] STATUS_KEY_SET   = 8'h82;

	localparam logic [19:0] KEY_HOLD_CYCLES   = 20'd500000;
	localparam logic [7:0]  TIMER_HOLD_CYCLES = 8'd100;
	localparam int unsigned TIMER_LOW_MARK    = 5;

	// display window in raster lines (exclusive bounds)
	localparam logic [8:0] DISPLAY_FIRST_EXCL = 9'd47;
	localparam logic [8:0] DISPLAY_END_EXCL   = 9'd264;
	localparam logic [8:0] LOWER_AREA_LINE    = 9'd200;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned Q_AW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	typedef enum logic [2:0] {
		OP_TICK,
		OP_WRITE,
		OP_READ,
		OP_KEY,
		OP_RELEASE,
		OP_NOP
	} op_t;

	typedef enum logic [3:0] {
		RSEL_STATUS,
		RSEL_PORTC,
		RSEL_KEYCTL,
		RSEL_TCTRL,
		RSEL_TMSB,
		RSEL_TLSB,
		RSEL_LINE,
		RSEL_AUX,
		RSEL_WINDOW,
		RSEL_NONE
	} rsel_t;

	typedef struct packed {
		op_t        op;
		rsel_t      rsel;
		logic [6:0] cyc;    // already clamped to one line
		logic [7:0] wdata;
	} item_t;

	typedef struct packed {
		logic [8:0] line_number;
		logic       sound_mute;
		logic       line_end;
		logic       draw_segment;
		logic       irq_line;
		logic [7:0] read_data;
	} result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tvsu_front.sv =====
// tvsu_front: accepts input words, decodes command and register offset,
// clamps the tick length and hands classified items to the queue
// depends on tvsu_pkg
`default_nettype none

module tvsu_front #(
	parameter int unsigned CYCLES_PER_LINE = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [2:0]    cmd,
	input  wire logic [6:0]    cycles,
	input  wire logic [5:0]    reg_addr,
	input  wire logic [7:0]    write_data,
	output logic               push_valid,
	input  wire logic          push_ready,
	output tvsu_pkg::item_t    push_item
);
	import tvsu_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	item_t item_d;

	always_comb begin
		item_d = '0;
		unique case (cmd)
			CMD_TICK:    item_d.op = OP_TICK;
			CMD_WRITE:   item_d.op = OP_WRITE;
			CMD_READ:    item_d.op = OP_READ;
			CMD_KEY:     item_d.op = OP_KEY;
			CMD_RELEASE: item_d.op = OP_RELEASE;
			default:     item_d.op = OP_NOP;
		endcase
		unique case (reg_addr)
			ADDR_STATUS: item_d.rsel = RSEL_STATUS;
			ADDR_PORTC:  item_d.rsel = RSEL_PORTC;
			ADDR_KEYCTL: item_d.rsel = RSEL_KEYCTL;
			ADDR_TCTRL:  item_d.rsel = RSEL_TCTRL;
			ADDR_TMSB:   item_d.rsel = RSEL_TMSB;
			ADDR_TLSB:   item_d.rsel = RSEL_TLSB;
			ADDR_LINE:   item_d.rsel = RSEL_LINE;
			ADDR_AUX:    item_d.rsel = RSEL_AUX;
			ADDR_WINDOW: item_d.rsel = RSEL_WINDOW;
			default:     item_d.rsel = RSEL_NONE;
		endcase
		// a tick longer than a line counts as one line
		item_d.cyc   = (cycles > 7'(CYCLES_PER_LINE)) ? 7'(CYCLES_PER_LINE) : cycles;
		item_d.wdata = write_data;
	end

	assign s_tready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tvsu_queue.sv =====
// tvsu_queue: short first-in first-out queue of classified items
// between the front and the back
// depends on tvsu_pkg
`default_nettype none

module tvsu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tvsu_pkg::item_t in_item,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tvsu_pkg::item_t    out_item
);
	import tvsu_pkg::*;

	item_t            slot_q [QUEUE_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_AW:0]    count_q;
	logic             push;
	logic             pop;

	assign in_ready  = (count_q != (Q_AW+1)'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (Q_AW+1)'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count missed a pop");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tvsu_back.sv =====
// tvsu_back: raster, timer and interrupt state; executes one queued item
// per cycle unless stalled and holds the result word in an output register
// depends on tvsu_pkg
`default_nettype none

module tvsu_back #(
	parameter int unsigned FRAMES_PER_DRAW = 2,
	parameter int unsigned CYCLES_PER_LINE = 64,
	parameter int unsigned LINES_PER_FRAME = 312
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            q_valid,
	output logic                 q_pop,
	input  wire tvsu_pkg::item_t q_item,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output tvsu_pkg::result_t    res
);
	import tvsu_pkg::*;

	localparam int unsigned FC_W = (FRAMES_PER_DRAW > 1) ? $clog2(FRAMES_PER_DRAW) : 1;

	logic [5:0]      line_cycle_q, line_cycle_d;
	logic [8:0]      raster_q, raster_d;
	logic [FC_W-1:0] frame_q, frame_d;
	logic            disp_q, disp_d;
	logic [7:0]      status_q, status_d;
	logic [7:0]      tctrl_q, tctrl_d;
	logic [15:0]     latch_q, latch_d;
	logic [20:0]     tcount_q, tcount_d;
	logic [7:0]      thold_q, thold_d;
	logic [19:0]     khold_q, khold_d;
	logic            irq_q, irq_d;
	logic            mute_q, mute_d;
	logic            aux_q, aux_d;

	logic            out_valid_q;
	result_t         res_q;

	logic [6:0]      lc_sum;
	logic [9:0]      raster_inc;
	logic [FC_W:0]   frame_inc;
	logic [9:0]      tmr_sub;
	logic            tmr_reload;
	logic [20:0]     tmr_diff;
	logic            line_win;
	logic            frame_win;
	logic [7:0]      rd_data;
	logic            seg;
	logic            lend;

	assign q_pop = q_valid && (!out_valid_q || m_tready);

	assign lc_sum     = {1'b0, line_cycle_q} + q_item.cyc;
	assign raster_inc = {1'b0, raster_q} + 10'd1;
	assign frame_inc  = {1'b0, frame_q} + 1'b1;

	// timer runs at cycles or cycles*8, frozen while control bit 0 is set
	assign tmr_sub    = tctrl_q[0] ? 10'd0 :
	                    (tctrl_q[2] ? {3'b000, q_item.cyc} : {q_item.cyc, 3'b000});
	assign tmr_reload = {1'b0, tcount_q} < (22'(tmr_sub) + 22'(TIMER_LOW_MARK + 1));
	assign tmr_diff   = tcount_q - 21'(tmr_sub);

	assign line_win  = (line_cycle_q >= 6'd11) && (line_cycle_q <= 6'd51);
	assign frame_win = (raster_q >= 9'd56) && (raster_q <= 9'd255) &&
	                   !((raster_q == 9'd56) && (line_cycle_q < 6'd12)) &&
	                   !((raster_q == 9'd255) && (line_cycle_q > 6'd50));

	always_comb begin
		rd_data = '0;
		unique case (q_item.rsel)
			RSEL_STATUS: rd_data = (status_q != '0) ? (status_q | STATUS_ANY) : 8'h00;
			RSEL_TCTRL:  rd_data = tctrl_q;
			RSEL_TMSB:   rd_data = tcount_q[18:11];
			RSEL_TLSB:   rd_data = tcount_q[10:3];
			RSEL_LINE:   rd_data = (raster_q < LOWER_AREA_LINE) ? 8'h00 : 8'h02;
			RSEL_WINDOW: rd_data = {frame_win, 1'b0, line_win, 4'b0000, aux_q};
			default:     rd_data = '0;
		endcase
	end

	always_comb begin
		line_cycle_d = line_cycle_q;
		raster_d     = raster_q;
		frame_d      = frame_q;
		disp_d       = disp_q;
		status_d     = status_q;
		tctrl_d      = tctrl_q;
		latch_d      = latch_q;
		tcount_d     = tcount_q;
		thold_d      = thold_q;
		khold_d      = khold_q;
		irq_d        = irq_q;
		mute_d       = mute_q;
		aux_d        = aux_q;
		seg          = 1'b0;
		lend         = 1'b0;
		unique case (q_item.op)
			OP_TICK: begin
				seg = disp_q;
				if (lc_sum >= 7'(CYCLES_PER_LINE)) begin
					line_cycle_d = 6'(lc_sum - 7'(CYCLES_PER_LINE));
					lend = disp_q;
					if (raster_inc >= 10'(LINES_PER_FRAME)) begin
						raster_d = '0;
						frame_d  = (frame_inc >= (FC_W+1)'(FRAMES_PER_DRAW)) ?
						           '0 : frame_inc[FC_W-1:0];
					end else begin
						raster_d = raster_inc[8:0];
					end
					disp_d = (frame_d == '0) && (raster_d > DISPLAY_FIRST_EXCL) &&
					         (raster_d < DISPLAY_END_EXCL);
				end else begin
					line_cycle_d = lc_sum[5:0];
				end
				thold_d = (thold_q > {1'b0, q_item.cyc}) ? thold_q - {1'b0, q_item.cyc} : '0;
				if (thold_d == '0) begin
					status_d[0] = 1'b0;
				end
				khold_d = (khold_q > {13'd0, q_item.cyc}) ? khold_q - {13'd0, q_item.cyc} : '0;
				if (khold_d == '0) begin
					status_d[1] = 1'b0;
				end
				if (status_d[2:0] == 3'b000) begin
					status_d[7] = 1'b0;
					irq_d       = 1'b0;
				end
				if (tmr_reload) begin
					thold_d  = TIMER_HOLD_CYCLES;
					tcount_d = {2'b00, latch_q, 3'b000};
					status_d = status_d | STATUS_TIMER_SET;
					irq_d    = 1'b1;
				end else begin
					tcount_d = tmr_diff;
				end
			end
			OP_WRITE: begin
				unique case (q_item.rsel)
					RSEL_STATUS: status_d = q_item.wdata;
					RSEL_PORTC:  mute_d = q_item.wdata[3];
					RSEL_KEYCTL: begin
						if (!q_item.wdata[5]) begin
							khold_d = '0;
						end
					end
					RSEL_TCTRL: begin
						tctrl_d = q_item.wdata;
						if (q_item.wdata[0]) begin
							tcount_d = {2'b00, latch_q, 3'b000};
						end
					end
					RSEL_TMSB:   latch_d = {q_item.wdata, latch_q[7:0]};
					RSEL_TLSB:   latch_d = {latch_q[15:8], q_item.wdata};
					RSEL_AUX:    aux_d = q_item.wdata[0];
					default:     ;
				endcase
			end
			OP_KEY: begin
				status_d = status_q | STATUS_KEY_SET;
				khold_d  = KEY_HOLD_CYCLES;
				irq_d    = 1'b1;
			end
			OP_RELEASE: khold_d = '0;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_cycle_q <= '0;
			raster_q     <= '0;
			frame_q      <= '0;
			disp_q       <= 1'b0;
			status_q     <= '0;
			tctrl_q      <= '0;
			latch_q      <= 16'hffff;
			tcount_q     <= 21'd65535;
			thold_q      <= '0;
			khold_q      <= '0;
			irq_q        <= 1'b0;
			mute_q       <= 1'b0;
			aux_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				line_cycle_q <= line_cycle_d;
				raster_q     <= raster_d;
				frame_q      <= frame_d;
				disp_q       <= disp_d;
				status_q     <= status_d;
				tctrl_q      <= tctrl_d;
				latch_q      <= latch_d;
				tcount_q     <= tcount_d;
				thold_q      <= thold_d;
				khold_q      <= khold_d;
				irq_q        <= irq_d;
				mute_q       <= mute_d;
				aux_q        <= aux_d;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q.read_data    <= (q_item.op == OP_READ) ? rd_data : 8'h00;
			res_q.irq_line     <= irq_d;
			res_q.draw_segment <= seg;
			res_q.line_end     <= lend;
			res_q.sound_mute   <= mute_d;
			res_q.line_number  <= raster_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign res      = res_q;

`ifndef SYNTH
	a_line_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, line_cycle_q} < 7'(CYCLES_PER_LINE))
		else $error("line cycle out of range");
	a_raster: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, raster_q} < 10'(LINES_PER_FRAME))
		else $error("raster line out of range");
	a_frame: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, frame_q} < (FC_W+1)'(FRAMES_PER_DRAW))
		else $error("frame count out of range");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/timer_and_video_sync_unit_core.sv =====
// timer_and_video_sync_unit_core: top level of the timer and video sync unit
// instantiates tvsu_front, tvsu_queue and tvsu_back; uses tvsu_pkg
`default_nettype none

// Raster position, interval timer and interrupt status of the gate array.
// Every input word (tick, register write, register read, key press, key
// release) gives exactly one output word. The unit sustains one word per
// clock while m_tready does not stall the output: the back end applies
// a whole item, tick arithmetic included, in one update of its state
// registers, and that update loop sets the rate. An accepted word is
// loaded into the front decode register, then moved into the two-entry
// queue, and then the back end loads the output register, where the
// output word becomes valid. The input stays ready while an output word
// waits, until the queue and the front register fill.
module timer_and_video_sync_unit_core #(
	parameter int unsigned FRAMES_PER_DRAW = 2,
	parameter int unsigned CYCLES_PER_LINE = 64,
	parameter int unsigned LINES_PER_FRAME = 312
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // cycles[6:0], reg_addr[12:7], write_data[20:13], zero
	input  wire logic [2:0]  s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // read_data[7:0], irq_line[8], draw_segment[9],
	                                    // line_end[10], sound_mute[11], line_number[20:12], zero
);
	import tvsu_pkg::*;

	logic    push_valid;
	logic    push_ready;
	item_t   push_item;
	logic    q_valid;
	logic    q_pop;
	item_t   q_item;
	result_t res;

	tvsu_front #(
		.CYCLES_PER_LINE(CYCLES_PER_LINE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.cmd        (s_tuser),
		.cycles     (s_tdata[6:0]),
		.reg_addr   (s_tdata[12:7]),
		.write_data (s_tdata[20:13]),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	tvsu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_item   (push_item),
		.out_valid (q_valid),
		.out_ready (q_pop),
		.out_item  (q_item)
	);

	tvsu_back #(
		.FRAMES_PER_DRAW(FRAMES_PER_DRAW),
		.CYCLES_PER_LINE(CYCLES_PER_LINE),
		.LINES_PER_FRAME(LINES_PER_FRAME)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {3'b000, res.line_number, res.sound_mute, res.line_end,
	                  res.draw_segment, res.irq_line, res.read_data};

endmodule

`default_nettype wire
